// ===== rtl/amtd_pkg.sv =====
// shared constants, codes and control structs of the adaptive morse timing decoder
// no dependencies
package amtd_pkg;

    localparam int DEF_EVENT_DEPTH = 64;
    localparam int DEF_TIME_BITS   = 32;
    localparam int DATA_BITS       = 32;
    localparam int CFG_IDX_BITS    = 3;
    localparam int INIT_MIN        = 1000;
    localparam int WORD_GAP_RESET  = 1000;
    localparam int MAX_OUT         = 63;
    localparam int OUT_CNT_BITS    = 7;

    localparam logic [CFG_IDX_BITS-1:0] CFG_AUTO  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DOT   = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DASH  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SYMG  = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CHARG = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_WORDG = 3'd5;

    localparam logic REQ_EDGE  = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    localparam logic [1:0] SYM_DOT   = 2'd0;
    localparam logic [1:0] SYM_DASH  = 2'd1;
    localparam logic [1:0] SYM_CHARG = 2'd2;
    localparam logic [1:0] SYM_WORDG = 2'd3;

    typedef struct packed {
        logic store;
        logic check;
        logic rd_en;
        logic adapt_step;
        logic fin1;
        logic fin2;
        logic fin3;
        logic dec_init;
        logic dec_step;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic fire;
    } stat_t;

endpackage

// ===== rtl/amtd_ctrl.sv =====
// sequencer of the adaptive morse timing decoder: accepts items, walks the edge store twice
// depends on amtd_pkg
module amtd_ctrl #(
    parameter int EVENT_DEPTH = amtd_pkg::DEF_EVENT_DEPTH,
    parameter int AW          = $clog2(EVENT_DEPTH),
    parameter int CW          = $clog2(EVENT_DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 req_type,
    output logic                 busy,
    input  amtd_pkg::stat_t      stat,
    input  logic [CW-1:0]        edge_count,
    output amtd_pkg::cmd_t       cmd,
    output logic [AW-1:0]        rd_addr
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADAPT,
        S_ADAPT_TAIL,
        S_FIN1,
        S_FIN2,
        S_FIN3,
        S_DEC_INIT,
        S_DECODE,
        S_DEC_TAIL,
        S_FINISH
    } state_t;

    state_t        state_reg;
    logic [AW-1:0] idx_reg;
    logic          step_reg;
    logic          busy_reg;
    logic          last_idx;
    logic          accept;

    assign accept   = start && !busy_reg;
    assign last_idx = (CW'(idx_reg) == (edge_count - CW'(1)));
    assign busy     = busy_reg;
    assign rd_addr  = idx_reg;

    always_comb
    begin
        cmd            = '0;
        cmd.store      = accept && (req_type == amtd_pkg::REQ_EDGE);
        cmd.check      = accept && (req_type == amtd_pkg::REQ_CHECK);
        cmd.rd_en      = (state_reg == S_ADAPT) || (state_reg == S_DECODE);
        cmd.adapt_step = step_reg && ((state_reg == S_ADAPT) || (state_reg == S_ADAPT_TAIL));
        cmd.dec_step   = step_reg && ((state_reg == S_DECODE) || (state_reg == S_DEC_TAIL));
        cmd.fin1       = (state_reg == S_FIN1);
        cmd.fin2       = (state_reg == S_FIN2);
        cmd.fin3       = (state_reg == S_FIN3);
        cmd.dec_init   = (state_reg == S_DEC_INIT);
        cmd.finish     = (state_reg == S_FINISH);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            step_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= cmd.rd_en;
            unique case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    if (cmd.check && stat.fire)
                    begin
                        state_reg <= S_ADAPT;
                        busy_reg  <= 1'b1;
                    end
                end
                S_ADAPT:
                begin
                    if (last_idx)
                    begin
                        state_reg <= S_ADAPT_TAIL;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                S_ADAPT_TAIL:
                begin
                    state_reg <= S_FIN1;
                end
                S_FIN1:
                begin
                    state_reg <= S_FIN2;
                end
                S_FIN2:
                begin
                    state_reg <= S_FIN3;
                end
                S_FIN3:
                begin
                    state_reg <= S_DEC_INIT;
                end
                S_DEC_INIT:
                begin
                    idx_reg   <= '0;
                    state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    if (last_idx)
                    begin
                        state_reg <= S_DEC_TAIL;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + AW'(1);
                    end
                end
                S_DEC_TAIL:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    busy_reg  <= 1'b0;
                end
            endcase
        end
    end

endmodule

// ===== rtl/amtd_dpath.sv =====
// datapath of the adaptive morse timing decoder: edge store, estimates, both passes, result register
// depends on amtd_pkg
module amtd_dpath #(
    parameter int EVENT_DEPTH = amtd_pkg::DEF_EVENT_DEPTH,
    parameter int TIME_BITS   = amtd_pkg::DEF_TIME_BITS,
    parameter int AW          = $clog2(EVENT_DEPTH),
    parameter int CW          = $clog2(EVENT_DEPTH + 1)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  amtd_pkg::cmd_t                        cmd,
    input  logic [AW-1:0]                         rd_addr,
    output amtd_pkg::stat_t                       stat,
    output logic [CW-1:0]                         edge_count,
    input  logic                                  key_down,
    input  logic [amtd_pkg::DATA_BITS-1:0]        time_ms,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [amtd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [amtd_pkg::DATA_BITS-1:0]        cfg_data,
    output logic                                  result_valid,
    output logic [1:0]                            symbol,
    output logic                                  last,
    output logic                                  dropped_events
);

    localparam logic [TIME_BITS-1:0] TMAX     = '1;
    localparam logic [TIME_BITS-1:0] INIT_MIN = TIME_BITS'(amtd_pkg::INIT_MIN);

    typedef logic [TIME_BITS-1:0] tm_t;

    function automatic tm_t avg2(tm_t a, tm_t b);
        return (a >> 1) + (b >> 1) + tm_t'(a[0] & b[0]);
    endfunction

    function automatic tm_t mul3(tm_t a);
        logic [TIME_BITS+1:0] p;
        p = (TIME_BITS+2)'(a) + ((TIME_BITS+2)'(a) << 1);
        return (p[TIME_BITS+1:TIME_BITS] != 2'b00) ? TMAX : p[TIME_BITS-1:0];
    endfunction

    function automatic tm_t mul2(tm_t a);
        return a[TIME_BITS-1] ? TMAX : (a << 1);
    endfunction

    function automatic tm_t mid(tm_t lo, tm_t hi);
        return (hi >= lo) ? lo + ((hi - lo) >> 1) : lo - ((lo - hi) >> 1);
    endfunction

    logic [TIME_BITS:0] mem [EVENT_DEPTH];
    logic [TIME_BITS:0] rd_data_reg;

    logic          auto_reg;
    tm_t           dot_reg, dash_reg, symg_reg, charg_reg, word_reg;
    tm_t           last_time_reg, chk_time_reg;
    logic          ovf_reg;
    logic [CW-1:0] count_reg;
    tm_t           ams_reg, ags_reg, minm_reg, maxm_reg, ming_reg, g3_reg;
    tm_t           on_reg, off_reg, dd_reg, sc_reg;
    logic [amtd_pkg::OUT_CNT_BITS-1:0] ocnt_reg;
    logic          pend_valid_reg;
    logic [1:0]    pend_sym_reg;
    logic          rv_reg, last_out_reg, drop_out_reg;
    logic [1:0]    sym_out_reg;

    tm_t  tin, cfg_v, elapsed, rt;
    logic rk, past;
    tm_t  ams1, ags1, on1, off1, dm, dg, dmark, dgap;
    logic a_mark, a_gap, d_mark, d_gap, d_hit;
    logic [1:0] d_sym;

    assign tin        = TIME_BITS'(time_ms);
    assign cfg_v      = ((cfg_data >> TIME_BITS) != '0) ? TMAX : TIME_BITS'(cfg_data);
    assign elapsed    = tin - last_time_reg;
    assign past       = (elapsed >= word_reg);
    assign stat.fire  = past && (count_reg != '0);
    assign edge_count = count_reg;
    assign cfg_ready  = 1'b1;
    assign rt         = rd_data_reg[TIME_BITS-1:0];
    assign rk         = rd_data_reg[TIME_BITS];

    assign ags1   = (!rk && ags_reg == '0) ? rt : ags_reg;
    assign ams1   = (rk && ams_reg == '0) ? rt : ams_reg;
    assign a_mark = (ams1 < ags1) && (ags1 != '0) && (ams1 != '0);
    assign a_gap  = (ags1 < ams1) && (ags1 != '0) && (ams1 != '0);
    assign dm     = ags1 - ams1;
    assign dg     = ams1 - ags1;

    assign off1   = (!rk && off_reg == '0) ? rt : off_reg;
    assign on1    = (rk && on_reg == '0) ? rt : on_reg;
    assign d_mark = (on1 < off1) && (off1 != '0) && (on1 != '0);
    assign d_gap  = (off1 < on1) && (off1 != '0) && (on1 != '0);
    assign dmark  = off1 - on1;
    assign dgap   = on1 - off1;

    always_comb
    begin
        d_hit = 1'b0;
        d_sym = amtd_pkg::SYM_DOT;
        if (d_mark)
        begin
            d_hit = 1'b1;
            d_sym = (dmark <= dd_reg) ? amtd_pkg::SYM_DOT : amtd_pkg::SYM_DASH;
        end
        else if (d_gap && (dgap > sc_reg))
        begin
            d_hit = 1'b1;
            d_sym = (dgap < word_reg) ? amtd_pkg::SYM_CHARG : amtd_pkg::SYM_WORDG;
        end
    end

    // edge store
    always_ff @(posedge clk)
    begin
        if (cmd.store && (count_reg < CW'(EVENT_DEPTH)))
        begin
            mem[count_reg[AW-1:0]] <= {key_down, tin};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            auto_reg       <= 1'b1;
            dot_reg        <= '0;
            dash_reg       <= '0;
            symg_reg       <= '0;
            charg_reg      <= '0;
            word_reg       <= TIME_BITS'(amtd_pkg::WORD_GAP_RESET);
            last_time_reg  <= '0;
            chk_time_reg   <= '0;
            ovf_reg        <= 1'b0;
            count_reg      <= '0;
            ams_reg        <= '0;
            ags_reg        <= '0;
            minm_reg       <= '0;
            maxm_reg       <= '0;
            ming_reg       <= '0;
            g3_reg         <= '0;
            on_reg         <= '0;
            off_reg        <= '0;
            dd_reg         <= '0;
            sc_reg         <= '0;
            ocnt_reg       <= '0;
            pend_valid_reg <= 1'b0;
            pend_sym_reg   <= amtd_pkg::SYM_DOT;
            rv_reg         <= 1'b0;
            sym_out_reg    <= amtd_pkg::SYM_DOT;
            last_out_reg   <= 1'b0;
            drop_out_reg   <= 1'b0;
        end
        else
        begin
            rv_reg <= 1'b0;

            if (cfg_valid)
            begin
                unique case (cfg_index)
                    amtd_pkg::CFG_AUTO:  auto_reg  <= cfg_data[0];
                    amtd_pkg::CFG_DOT:   dot_reg   <= cfg_v;
                    amtd_pkg::CFG_DASH:  dash_reg  <= cfg_v;
                    amtd_pkg::CFG_SYMG:  symg_reg  <= cfg_v;
                    amtd_pkg::CFG_CHARG: charg_reg <= cfg_v;
                    amtd_pkg::CFG_WORDG: word_reg  <= cfg_v;
                    default: ;
                endcase
            end

            if (cmd.store)
            begin
                if (count_reg < CW'(EVENT_DEPTH))
                begin
                    count_reg <= count_reg + CW'(1);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
                last_time_reg <= tin;
            end

            if (cmd.check && past)
            begin
                if (count_reg == '0)
                begin
                    last_time_reg <= tin;
                end
                else
                begin
                    chk_time_reg <= tin;
                    minm_reg     <= INIT_MIN;
                    maxm_reg     <= '0;
                    ming_reg     <= INIT_MIN;
                end
            end

            // first walk: pairing and extremes
            if (cmd.adapt_step)
            begin
                if (a_mark)
                begin
                    if (auto_reg && (dm < minm_reg)) minm_reg <= dm;
                    if (auto_reg && (dm > maxm_reg)) maxm_reg <= dm;
                    ams_reg <= '0;
                    ags_reg <= ags1;
                end
                else if (a_gap)
                begin
                    if (auto_reg && (dg < ming_reg)) ming_reg <= dg;
                    ags_reg <= '0;
                    ams_reg <= ams1;
                end
                else
                begin
                    ams_reg <= ams1;
                    ags_reg <= ags1;
                end
            end

            if (cmd.fin1 && auto_reg)
            begin
                dot_reg  <= (dot_reg != '0) ? avg2(dot_reg, minm_reg) : minm_reg;
                dash_reg <= (dash_reg != '0) ? avg2(dash_reg, maxm_reg) : maxm_reg;
                g3_reg   <= mul3(ming_reg);
            end

            if (cmd.fin2 && auto_reg)
            begin
                if (ming_reg != '0)
                begin
                    symg_reg  <= avg2(symg_reg, ming_reg);
                    charg_reg <= avg2(charg_reg, g3_reg);
                end
                else
                begin
                    symg_reg  <= dot_reg;
                    charg_reg <= mul3(dot_reg);
                end
            end

            if (cmd.fin3 && auto_reg)
            begin
                word_reg <= mul2(charg_reg);
            end

            if (cmd.dec_init)
            begin
                on_reg         <= '0;
                off_reg        <= '0;
                ocnt_reg       <= '0;
                pend_valid_reg <= 1'b0;
                dd_reg         <= mid(dot_reg, dash_reg);
                sc_reg         <= mid(symg_reg, charg_reg);
            end

            // second walk: classify, hold one symbol back to mark the final one
            if (cmd.dec_step)
            begin
                on_reg  <= d_mark ? '0 : on1;
                off_reg <= (d_gap && !d_mark) ? '0 : off1;
                if (d_hit && (ocnt_reg < amtd_pkg::OUT_CNT_BITS'(amtd_pkg::MAX_OUT)))
                begin
                    if (pend_valid_reg)
                    begin
                        rv_reg       <= 1'b1;
                        sym_out_reg  <= pend_sym_reg;
                        last_out_reg <= 1'b0;
                        drop_out_reg <= ovf_reg;
                    end
                    pend_valid_reg <= 1'b1;
                    pend_sym_reg   <= d_sym;
                    ocnt_reg       <= ocnt_reg + amtd_pkg::OUT_CNT_BITS'(1);
                end
            end

            if (cmd.finish)
            begin
                if (pend_valid_reg)
                begin
                    rv_reg       <= 1'b1;
                    sym_out_reg  <= pend_sym_reg;
                    last_out_reg <= 1'b1;
                    drop_out_reg <= ovf_reg;
                end
                pend_valid_reg <= 1'b0;
                count_reg      <= '0;
                ovf_reg        <= 1'b0;
                last_time_reg  <= chk_time_reg;
            end
        end
    end

    assign result_valid   = rv_reg;
    assign symbol         = sym_out_reg;
    assign last           = last_out_reg;
    assign dropped_events = drop_out_reg;

endmodule

// ===== rtl/adaptive_morse_timing_decoder_top.sv =====
// Adaptive morse timing decoder. A key edge (req_type 0) is taken and stored; edges beyond
// EVENT_DEPTH are dropped and flagged. A time check (req_type 1) that finds the word gap
// elapsed since the last edge flushes the store: busy stays high while the two walks run over
// the edge memory at one edge a cycle, with three estimate-update steps between them and the
// read register, setup and wrap-up states around them.
// Symbols come out one per result_valid pulse during the second walk and just after it, with
// last on the final one; there is no back-pressure, every pulse must be taken.
// depends on amtd_pkg, amtd_ctrl, amtd_dpath
module adaptive_morse_timing_decoder_top #(
    parameter int EVENT_DEPTH = amtd_pkg::DEF_EVENT_DEPTH,
    parameter int TIME_BITS   = amtd_pkg::DEF_TIME_BITS
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic                                  req_type,
    input  logic                                  key_down,
    input  logic [amtd_pkg::DATA_BITS-1:0]        time_ms,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [amtd_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  logic [amtd_pkg::DATA_BITS-1:0]        cfg_data,
    output logic                                  result_valid,
    output logic [1:0]                            symbol,
    output logic                                  last,
    output logic                                  dropped_events
);

    localparam int AW = $clog2(EVENT_DEPTH);
    localparam int CW = $clog2(EVENT_DEPTH + 1);

    amtd_pkg::cmd_t  cmd;
    amtd_pkg::stat_t stat;
    logic [AW-1:0]   rd_addr;
    logic [CW-1:0]   edge_count;

    amtd_ctrl #(
        .EVENT_DEPTH (EVENT_DEPTH),
        .AW          (AW),
        .CW          (CW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .req_type   (req_type),
        .busy       (busy),
        .stat       (stat),
        .edge_count (edge_count),
        .cmd        (cmd),
        .rd_addr    (rd_addr)
    );

    amtd_dpath #(
        .EVENT_DEPTH (EVENT_DEPTH),
        .TIME_BITS   (TIME_BITS),
        .AW          (AW),
        .CW          (CW)
    ) u_dpath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .rd_addr        (rd_addr),
        .stat           (stat),
        .edge_count     (edge_count),
        .key_down       (key_down),
        .time_ms        (time_ms),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result_valid   (result_valid),
        .symbol         (symbol),
        .last           (last),
        .dropped_events (dropped_events)
    );

`ifndef SYNTHESIS
    a_rd_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (CW'(rd_addr) < edge_count))
        else $error("edge store read beyond fill count");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |=> !result_valid)
        else $error("symbol after final symbol of a message");

    a_busy_from_check: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start && (req_type == amtd_pkg::REQ_CHECK)))
        else $error("flush started without a time check");

    a_no_store_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !cmd.store)
        else $error("edge stored while flushing");
`endif

endmodule

// ===== dv/adaptive_morse_timing_decoder_top_test.sv =====
// testbench for adaptive_morse_timing_decoder_top: drives key edges and time checks, predicts
// symbols with an in-bench timing model and checks every result strobe in order
// depends on amtd_pkg and the rtl of adaptive_morse_timing_decoder_top
`timescale 1ns / 1ps

module adaptive_morse_timing_decoder_top_test;

    localparam longint unsigned TMAX = 64'hFFFF_FFFF;
    localparam int DEPTH = amtd_pkg::DEF_EVENT_DEPTH;
    localparam int FLUSH_WAIT = 2 * DEPTH + 40;
    localparam longint CYCLE_LIMIT = 2000000;
    localparam logic [amtd_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [amtd_pkg::CFG_IDX_BITS-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct {
        logic [1:0] symbol;
        logic       last;
        logic       dropped;
    } symbol_item_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic req_type = amtd_pkg::REQ_EDGE;
    logic key_down = 1'b0;
    logic [amtd_pkg::DATA_BITS-1:0] time_ms = '0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [amtd_pkg::CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [amtd_pkg::DATA_BITS-1:0] cfg_data = '0;
    logic result_valid;
    logic [1:0] symbol;
    logic last;
    logic dropped_events;

    symbol_item_t pending_symbols[$];
    int  error_count = 0;
    longint cycle_count = 0;

    // timing model state
    logic            auto_on;
    longint unsigned dot_est, dash_est, symg_est, charg_est, wordg_now;
    longint unsigned stored_time[DEPTH];
    logic            stored_key[DEPTH];
    int              stored_count;
    longint unsigned mark_start, gap_start, last_edge;
    logic            lost_edges;

    adaptive_morse_timing_decoder_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type), .key_down(key_down), .time_ms(time_ms),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .symbol(symbol),
        .last(last), .dropped_events(dropped_events)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic longint unsigned floor_avg(longint unsigned a, longint unsigned b);
        return (a >> 1) + (b >> 1) + (a & b & 1);
    endfunction

    function automatic longint unsigned times_sat(longint unsigned a, longint unsigned k);
        if (a > TMAX / k)
            return TMAX;
        return a * k;
    endfunction

    function automatic longint unsigned half_way(longint unsigned lo, longint unsigned hi);
        if (hi >= lo)
            return lo + ((hi - lo) >> 1);
        return lo - ((lo - hi) >> 1);
    endfunction

    task automatic model_reset();
        auto_on = 1'b1;
        dot_est = 0;
        dash_est = 0;
        symg_est = 0;
        charg_est = 0;
        wordg_now = amtd_pkg::WORD_GAP_RESET;
        stored_count = 0;
        mark_start = 0;
        gap_start = 0;
        last_edge = 0;
        lost_edges = 1'b0;
    endtask

    task automatic adapt_estimates();
        longint unsigned min_mark, max_mark, min_gap, d, t;
        logic k;
        min_mark = amtd_pkg::INIT_MIN;
        max_mark = 0;
        min_gap = amtd_pkg::INIT_MIN;
        for (int i = 0; i < stored_count; i++)
        begin
            t = stored_time[i];
            k = stored_key[i];
            if (!k && gap_start == 0) gap_start = t;
            if (k && mark_start == 0) mark_start = t;
            if (mark_start < gap_start && gap_start != 0 && mark_start != 0)
            begin
                d = gap_start - mark_start;
                if (auto_on)
                begin
                    if (d < min_mark) min_mark = d;
                    if (d > max_mark) max_mark = d;
                end
                mark_start = 0;
            end
            else if (gap_start < mark_start && gap_start != 0 && mark_start != 0)
            begin
                d = mark_start - gap_start;
                if (auto_on && d < min_gap) min_gap = d;
                gap_start = 0;
            end
        end
        if (!auto_on)
            return;
        dot_est = dot_est != 0 ? floor_avg(dot_est, min_mark) : min_mark;
        dash_est = dash_est != 0 ? floor_avg(dash_est, max_mark) : max_mark;
        if (min_gap != 0)
        begin
            symg_est = floor_avg(symg_est, min_gap);
            charg_est = floor_avg(charg_est, times_sat(min_gap, 3));
        end
        else
        begin
            symg_est = dot_est;
            charg_est = times_sat(dot_est, 3);
        end
        wordg_now = times_sat(charg_est, 2);
    endtask

    task automatic decode_symbols();
        longint unsigned on_t, off_t, d, t, dot_dash, sym_char;
        logic k;
        logic hit;
        logic [1:0] sym;
        int cnt;
        symbol_item_t s;
        on_t = 0;
        off_t = 0;
        cnt = 0;
        dot_dash = half_way(dot_est, dash_est);
        sym_char = half_way(symg_est, charg_est);
        for (int i = 0; i < stored_count; i++)
        begin
            t = stored_time[i];
            k = stored_key[i];
            hit = 1'b0;
            sym = amtd_pkg::SYM_DOT;
            if (!k && off_t == 0) off_t = t;
            if (k && on_t == 0) on_t = t;
            if (on_t < off_t && off_t != 0 && on_t != 0)
            begin
                d = off_t - on_t;
                hit = 1'b1;
                sym = d <= dot_dash ? amtd_pkg::SYM_DOT : amtd_pkg::SYM_DASH;
                on_t = 0;
            end
            else if (off_t < on_t && off_t != 0 && on_t != 0)
            begin
                d = on_t - off_t;
                if (d > sym_char)
                begin
                    hit = 1'b1;
                    sym = d < wordg_now ? amtd_pkg::SYM_CHARG : amtd_pkg::SYM_WORDG;
                end
                off_t = 0;
            end
            if (hit && cnt < amtd_pkg::MAX_OUT)
            begin
                s.symbol = sym;
                s.last = 1'b0;
                s.dropped = lost_edges;
                pending_symbols.push_back(s);
                cnt++;
            end
        end
        if (cnt > 0)
            pending_symbols[pending_symbols.size() - 1].last = 1'b1;
    endtask

    task automatic model_item(logic rt, logic kd, longint unsigned t);
        if (rt == amtd_pkg::REQ_EDGE)
        begin
            if (stored_count < DEPTH)
            begin
                stored_time[stored_count] = t;
                stored_key[stored_count] = kd;
                stored_count++;
            end
            else
                lost_edges = 1'b1;
            last_edge = t;
            return;
        end
        if (((t - last_edge) & TMAX) < wordg_now)
            return;
        if (stored_count == 0)
        begin
            last_edge = t;
            return;
        end
        adapt_estimates();
        decode_symbols();
        stored_count = 0;
        lost_edges = 1'b0;
        last_edge = t;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 0;
        if (r < 9) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(logic rt, logic kd, longint unsigned t);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        req_type <= rt;
        key_down <= kd;
        time_ms <= t[31:0];
        @(posedge clk);
        while (busy) @(posedge clk);
        model_item(rt, kd, t & TMAX);
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending_symbols.size() != 0 || busy) @(posedge clk);
        repeat (FLUSH_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(logic [amtd_pkg::CFG_IDX_BITS-1:0] idx, logic [31:0] value);
        longint unsigned v;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        v = value;
        case (idx)
            amtd_pkg::CFG_AUTO:  auto_on = value[0];
            amtd_pkg::CFG_DOT:   dot_est = v;
            amtd_pkg::CFG_DASH:  dash_est = v;
            amtd_pkg::CFG_SYMG:  symg_est = v;
            amtd_pkg::CFG_CHARG: charg_est = v;
            amtd_pkg::CFG_WORDG: wordg_now = v;
            default: ;
        endcase
    endtask

    task automatic write_all(logic [31:0] a, logic [31:0] dt, logic [31:0] ds,
                             logic [31:0] sg, logic [31:0] cg, logic [31:0] wg);
        wait_quiet();
        write_reg(amtd_pkg::CFG_AUTO, a);
        write_reg(amtd_pkg::CFG_DOT, dt);
        write_reg(amtd_pkg::CFG_DASH, ds);
        write_reg(amtd_pkg::CFG_SYMG, sg);
        write_reg(amtd_pkg::CFG_CHARG, cg);
        write_reg(amtd_pkg::CFG_WORDG, wg);
    endtask

    // alternating press and release, then an optional early check and a flushing check
    task automatic send_message(int n_edges, longint unsigned base, int unit, bit early);
        longint unsigned t;
        int r;
        t = base;
        for (int i = 0; i < n_edges; i++)
        begin
            r = $urandom_range(0, 3);
            if (i % 2 == 0)
                t = (t + unit * (r < 2 ? 1 : 3) + $urandom_range(0, unit / 4 + 1)) & TMAX;
            else
                t = (t + unit * (r == 0 ? 1 : (r == 1 ? 3 : (r == 2 ? 7 : 1)))
                     + $urandom_range(0, unit / 4 + 1)) & TMAX;
            send_item(amtd_pkg::REQ_EDGE, (i % 2 == 0), t);
        end
        if (early && wordg_now > 1)
            send_item(amtd_pkg::REQ_CHECK, 1'($urandom_range(0, 1)),
                      (t + $urandom_range(0, 1)) & TMAX);
        send_item(amtd_pkg::REQ_CHECK, 1'($urandom_range(0, 1)),
                  (t + wordg_now + $urandom_range(0, 50)) & TMAX);
    endtask

    task automatic send_noise(int n);
        longint unsigned t;
        t = $urandom;
        for (int i = 0; i < n; i++)
        begin
            t = (t + $urandom_range(0, 3000)) & TMAX;
            send_item($urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)), t);
        end
        send_item(amtd_pkg::REQ_CHECK, 1'b0, (t + wordg_now + $urandom_range(0, 20)) & TMAX);
    endtask

    task automatic test_defaults();
        send_message(8, 100, 60, 1'b1);
        send_item(amtd_pkg::REQ_CHECK, 1'b1, TMAX);
    endtask

    task automatic test_config_extremes();
        write_all(32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
        send_message(4, 32'h1000, 50, 1'b1);
        write_all(32'hFFFF_FFFE, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0);
        write_reg(CFG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_HI, 32'h0);
        send_message(4, 32'h2000, 80, 1'b0);
        write_all(32'h1, 32'd60, 32'd180, 32'd60, 32'd180, 32'd420);
        send_message(6, 32'h3000, 60, 1'b1);
    endtask

    task automatic test_empty_and_zero_time();
        send_item(amtd_pkg::REQ_CHECK, 1'b0, 32'h5000_0000);
        send_item(amtd_pkg::REQ_EDGE, 1'b1, 0);
        send_item(amtd_pkg::REQ_EDGE, 1'b0, 40);
        send_item(amtd_pkg::REQ_EDGE, 1'b1, 100);
        send_item(amtd_pkg::REQ_EDGE, 1'b0, 300);
        send_item(amtd_pkg::REQ_CHECK, 1'b1, 300 + wordg_now);
    endtask

    task automatic test_wrap();
        send_message(6, TMAX - 150, 60, 1'b0);
    endtask

    task automatic test_overflow();
        wait_quiet();
        write_reg(amtd_pkg::CFG_WORDG, 32'd5000);
        send_message(DEPTH + 6, 32'h0010_0000, 40, 1'b0);
    endtask

    task automatic test_random();
        for (int m = 0; m < 15; m++)
        begin
            if (m % 6 == 5)
                write_all($urandom, $urandom_range(0, 200), $urandom_range(0, 600),
                          $urandom_range(0, 200), $urandom_range(0, 600),
                          $urandom_range(200, 3000));
            if ($urandom_range(0, 5) == 0)
                send_noise($urandom_range(3, 8));
            else
                send_message($urandom_range(2, 12), $urandom, $urandom_range(20, 150),
                             $urandom_range(0, 3) == 0);
        end
    endtask

    always @(posedge clk)
    begin
        symbol_item_t exp_item;
        if (rst_n && result_valid)
        begin
            if (pending_symbols.size() == 0)
            begin
                $error("unexpected symbol %0d", symbol);
                error_count++;
            end
            else
            begin
                exp_item = pending_symbols.pop_front();
                if (symbol !== exp_item.symbol)
                begin
                    $error("symbol: expected %0d actual %0d", exp_item.symbol, symbol);
                    error_count++;
                end
                if (last !== exp_item.last)
                begin
                    $error("last: expected %0d actual %0d", exp_item.last, last);
                    error_count++;
                end
                if (dropped_events !== exp_item.dropped)
                begin
                    $error("dropped_events: expected %0d actual %0d", exp_item.dropped,
                           dropped_events);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("** adaptive_morse_timing_decoder_top: FAILED **");
            $finish;
        end
    end

    initial
    begin
        model_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_config_extremes();
        test_empty_and_zero_time();
        test_wrap();
        test_overflow();
        test_random();
        wait_quiet();
        if (pending_symbols.size() != 0)
        begin
            $error("symbols left over: %0d", pending_symbols.size());
            error_count++;
        end
        if (error_count == 0)
            $display("** adaptive_morse_timing_decoder_top: PASSED **");
        else
            $display("** adaptive_morse_timing_decoder_top: FAILED **");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/amtd_pkg.sv
rtl/amtd_ctrl.sv
rtl/amtd_dpath.sv
rtl/adaptive_morse_timing_decoder_top.sv
dv/adaptive_morse_timing_decoder_top_test.sv
